>>> hdl/rcog_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the ray cast occupancy grid
package rcog_pkg;

  localparam int GRID_X_DEF = 256;
  localparam int GRID_Y_DEF = 256;

  localparam int COORD_W   = 8;
  localparam int CELL_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [COORD_W-1:0] SENSOR_RST = 8'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_Y = 2'd1;

  localparam logic [CELL_W-1:0] CELL_UNKNOWN  = 2'd0;
  localparam logic [CELL_W-1:0] CELL_FREE     = 2'd1;
  localparam logic [CELL_W-1:0] CELL_OCCUPIED = 2'd2;

  typedef enum logic [1:0] {
    KIND_CAST  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       load_line;
    logic       line_step;
    logic       occ_write;
    logic [1:0] occ_sel;
    logic       rd_issue;
    logic       out_load;
    logic       clr_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic line_last;
    logic clr_last;
  } sts_t;

endpackage

>>> hdl/rcog_grid_mem.sv
`timescale 1ns / 1ps
// single port cell store with registered read data
module rcog_grid_mem #(
  parameter int DEPTH = rcog_pkg::GRID_X_DEF * rcog_pkg::GRID_Y_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic                        re,
  input  logic [AW-1:0]               addr,
  input  logic [rcog_pkg::CELL_W-1:0] wdata,
  output logic [rcog_pkg::CELL_W-1:0] rdata
);

  logic [rcog_pkg::CELL_W-1:0] mem [DEPTH];
  logic [rcog_pkg::CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/rcog_datapath.sv
`timescale 1ns / 1ps
// line stepper, address generation, sensor registers and result register
module rcog_datapath #(
  parameter int GRID_X = rcog_pkg::GRID_X_DEF,
  parameter int GRID_Y = rcog_pkg::GRID_Y_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rcog_pkg::cmd_t                 cmd,
  output rcog_pkg::sts_t                 sts,
  input  logic [rcog_pkg::COORD_W-1:0]   in_cell_x,
  input  logic [rcog_pkg::COORD_W-1:0]   in_cell_y,
  input  logic                           cfg_we,
  input  logic [rcog_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rcog_pkg::COORD_W-1:0]   cfg_wdata,
  output logic [rcog_pkg::CELL_W-1:0]    out_cell_state
);

  localparam int DEPTH = GRID_X * GRID_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = rcog_pkg::COORD_W;
  localparam int EW    = CW + 2;

  logic [CW-1:0] sensor_x_r, sensor_y_r;
  logic [CW-1:0] cx_r, cy_r;

  // line state
  logic                 steep_r, down_r;
  logic [CW-1:0]        x_r, y_r, bx_r, run_r, rise_r;
  logic signed [EW-1:0] err_r;

  // setup
  logic [CW-1:0]        adx, ady, p0x, p0y, p1x, p1y, ax, ay, bx, by;
  logic                 steep, swap;
  logic signed [EW-1:0] e1;

  // write and read address
  logic [CW:0]                 wx, wy;
  logic                        in_grid;
  logic [AW-1:0]               addr;
  logic                        mem_we;
  logic [rcog_pkg::CELL_W-1:0] mem_wdata, mem_rdata;

  logic [AW-1:0]               clr_addr_r;
  logic                        rd_oob_r;
  logic [rcog_pkg::CELL_W-1:0] out_state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_x_r <= rcog_pkg::SENSOR_RST;
      sensor_y_r <= rcog_pkg::SENSOR_RST;
    end else if (cfg_we) begin
      if (cfg_idx == rcog_pkg::CFG_SENSOR_X) begin
        sensor_x_r <= cfg_wdata;
      end else if (cfg_idx == rcog_pkg::CFG_SENSOR_Y) begin
        sensor_y_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cx_r <= in_cell_x;
      cy_r <= in_cell_y;
    end
  end

  always_comb begin
    adx   = (sensor_x_r > cx_r) ? sensor_x_r - cx_r : cx_r - sensor_x_r;
    ady   = (sensor_y_r > cy_r) ? sensor_y_r - cy_r : cy_r - sensor_y_r;
    steep = ady > adx;
    p0x   = steep ? sensor_y_r : sensor_x_r;
    p0y   = steep ? sensor_x_r : sensor_y_r;
    p1x   = steep ? cy_r : cx_r;
    p1y   = steep ? cx_r : cy_r;
    swap  = p0x > p1x;
    ax    = swap ? p1x : p0x;
    ay    = swap ? p1y : p0y;
    bx    = swap ? p0x : p1x;
    by    = swap ? p0y : p1y;
  end

  assign e1 = err_r - $signed({2'b00, rise_r});

  always_ff @(posedge clk) begin
    if (cmd.load_line) begin
      steep_r <= steep;
      x_r     <= ax;
      y_r     <= ay;
      bx_r    <= bx;
      run_r   <= bx - ax;
      rise_r  <= (ay > by) ? ay - by : by - ay;
      down_r  <= !(ay < by);
      err_r   <= $signed({2'b00, (bx - ax) >> 1});
    end else if (cmd.line_step) begin
      x_r <= x_r + 1'b1;
      if (e1 < 0) begin
        y_r   <= down_r ? y_r - 1'b1 : y_r + 1'b1;
        err_r <= e1 + $signed({2'b00, run_r});
      end else begin
        err_r <= e1;
      end
    end
  end

  assign sts.line_last = (x_r == bx_r);
  assign sts.clr_last  = (clr_addr_r == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= sts.clr_last ? '0 : clr_addr_r + 1'b1;
    end
  end

  // coordinate of the cell touched this cycle
  always_comb begin
    priority if (cmd.line_step) begin
      wx = {1'b0, steep_r ? y_r : x_r};
      wy = {1'b0, steep_r ? x_r : y_r};
    end else if (cmd.occ_write) begin
      wx = {1'b0, cx_r} + (CW+1)'(cmd.occ_sel[1]);
      wy = {1'b0, cy_r} + (CW+1)'(cmd.occ_sel[0]);
    end else begin
      wx = {1'b0, cx_r};
      wy = {1'b0, cy_r};
    end
  end

  assign in_grid = (32'(wx) < GRID_X) && (32'(wy) < GRID_Y);

  always_comb begin
    if (cmd.clr_step) begin
      addr = clr_addr_r;
    end else begin
      addr = AW'(wx) * AW'(GRID_Y) + AW'(wy);
    end
  end

  assign mem_we    = cmd.clr_step || ((cmd.line_step || cmd.occ_write) && in_grid);
  assign mem_wdata = cmd.clr_step  ? rcog_pkg::CELL_UNKNOWN :
                     cmd.occ_write ? rcog_pkg::CELL_OCCUPIED : rcog_pkg::CELL_FREE;

  rcog_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (cmd.rd_issue),
    .addr  (addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_oob_r <= !in_grid;
    end
    if (cmd.out_load) begin
      out_state_r <= rd_oob_r ? rcog_pkg::CELL_UNKNOWN : mem_rdata;
    end
  end

  assign out_cell_state = out_state_r;

endmodule

>>> hdl/rcog_ctrl.sv
`timescale 1ns / 1ps
// sequencing of cast, read and clear items
module rcog_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic [1:0]     in_kind,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output rcog_pkg::cmd_t cmd,
  input  rcog_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_LINE,
    S_OCC,
    S_READ,
    S_RDATA
  } state_t;

  state_t     state_r;
  logic [1:0] occ_r;
  logic       out_valid_r;
  logic       accept;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.load_line = (state_r == S_SETUP);
    cmd.line_step = (state_r == S_LINE);
    cmd.occ_write = (state_r == S_OCC);
    cmd.occ_sel   = occ_r;
    cmd.rd_issue  = (state_r == S_READ);
    cmd.out_load  = (state_r == S_RDATA) && !out_valid_r;
    cmd.clr_step  = (state_r == S_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (sts.clr_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (in_kind)
              rcog_pkg::KIND_CAST:  state_r <= S_SETUP;
              rcog_pkg::KIND_READ:  state_r <= S_READ;
              rcog_pkg::KIND_CLEAR: state_r <= S_CLEAR;
              default:              state_r <= S_IDLE;
            endcase
          end
        end
        S_SETUP: begin
          state_r <= S_LINE;
        end
        S_LINE: begin
          if (sts.line_last) begin
            occ_r   <= '0;
            state_r <= S_OCC;
          end
        end
        S_OCC: begin
          occ_r <= occ_r + 1'b1;
          if (occ_r == 2'd3) begin
            state_r <= S_IDLE;
          end
        end
        S_READ: begin
          state_r <= S_RDATA;
        end
        S_RDATA: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/ray_cast_occupancy_grid.sv
`timescale 1ns / 1ps
// top level of the ray cast occupancy grid
//
// keeps a GRID_X by GRID_Y map of 2-bit cell codes: 0 unknown, 1 free, 2 occupied
// input beats: in_tuser is the item kind (0 cast, 1 read, 2 clear, 3 ignored),
//   in_tdata carries cell_x in [7:0] and cell_y in [15:8]
// a cast walks a bresenham line from the sensor cell to the hit cell, one cell
//   per cycle, marking it free, then marks the 2x2 block at the hit cell occupied;
//   in_tready stays low until the cast is done; the store has a single write
//   port, so these cells are written one at a time
// a read gives one output beat after its S_READ and S_RDATA states;
//   cells outside the grid read as unknown; cast and clear give no output beat
// a clear sweeps the store one cell per cycle, setting every cell to unknown
// after reset the same sweep runs with in_tready low
// cfg beats write sensor_cell_x (index 0) or sensor_cell_y (index 1), reset 128;
//   cfg_ready is always high, writes belong in idle periods only
// the result sits in an output register: while the receiver stalls, later cast
//   and clear items go ahead, and a further read waits until the register drains
module ray_cast_occupancy_grid #(
  parameter int GRID_X = rcog_pkg::GRID_X_DEF,
  parameter int GRID_Y = rcog_pkg::GRID_Y_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // cell_x [7:0], cell_y [15:8]
  input  logic [1:0]                     in_tuser,   // kind [1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // cell_state [1:0], zeros above
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcog_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcog_pkg::COORD_W-1:0]   cfg_data
);

  rcog_pkg::cmd_t              cmd;
  rcog_pkg::sts_t              sts;
  logic [rcog_pkg::CELL_W-1:0] cell_state;

  assign cfg_ready = 1'b1;

  rcog_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rcog_datapath #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_cell_x      (in_tdata[7:0]),
    .in_cell_y      (in_tdata[15:8]),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_idx        (cfg_index),
    .cfg_wdata      (cfg_data),
    .out_cell_state (cell_state)
  );

  assign out_tdata = {6'b000000, cell_state};

  // the store port serves one job per cycle
  a_one_store_job: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.line_step, cmd.occ_write, cmd.rd_issue}))
    else $error("two store jobs in one cycle");

  // no item is taken while the sweep runs
  a_no_accept_in_sweep: assert property (@(posedge clk)
    cmd.clr_step |-> !in_tready)
    else $error("input taken during clear sweep");

  // a clear item starts the sweep on the next cycle
  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == rcog_pkg::KIND_CLEAR) |=> cmd.clr_step)
    else $error("clear item did not start sweep");

  // a result register load only happens when the register is free
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_tvalid ##1 out_tvalid)
    else $error("result register overwritten");

endmodule
